>>> design/crc8d_pkg.sv
// shared types and constants of the crc8 packet deframer
package crc8d_pkg;

  localparam int MaxPayload = 32;
  localparam int ByteW      = 8;
  localparam int IdxW       = (MaxPayload > 1) ? $clog2(MaxPayload) : 1;
  localparam int LenW       = $clog2(MaxPayload + 1);
  localparam int AddrW      = IdxW + 1;

  localparam logic [ByteW-1:0] SyncReset = 8'hAA;
  localparam logic [ByteW-1:0] CrcPoly   = 8'h07;
  localparam logic [ByteW-1:0] CrcInit   = 8'h00;

  // packet descriptor handed from the parser to the emitter
  typedef struct packed {
    logic [ByteW-1:0] command;
    logic [LenW-1:0]  len;
    logic             bank;
  } desc_t;

  // queue control between parser, queue and emitter
  typedef struct packed {
    logic  push;
    desc_t desc;
  } push_t;

  typedef struct packed {
    logic  valid;
    logic  full;
    desc_t head;
  } qstat_t;

  // payload store write port
  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [ByteW-1:0] data;
  } wr_t;

endpackage

>>> design/crc8d_front.sv
// parser: sync hunt, length check, crc-8 and payload capture
module crc8d_front import crc8d_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic [ByteW-1:0] cfg_sync_value_i,
  input  logic             in_fire_i,
  input  logic [ByteW-1:0] rx_byte_i,
  output push_t            push_o,
  output wr_t              wr_o
);

  localparam logic [2:0] PhHunt = 3'd0;
  localparam logic [2:0] PhLen  = 3'd1;
  localparam logic [2:0] PhCmd  = 3'd2;
  localparam logic [2:0] PhPay  = 3'd3;
  localparam logic [2:0] PhCrc  = 3'd4;

  function automatic logic [ByteW-1:0] crc_feed(input logic [ByteW-1:0] crc,
                                                input logic [ByteW-1:0] b);
    logic [ByteW-1:0] c;
    c = crc ^ b;
    for (int k = 0; k < ByteW; k++) begin
      if (c[ByteW-1]) c = (c << 1) ^ CrcPoly;
      else c = c << 1;
    end
    return c;
  endfunction

  logic [2:0]       phase_q, phase_d;
  logic [LenW-1:0]  exp_q, exp_d;
  logic [ByteW-1:0] cmd_q, cmd_d;
  logic [LenW-1:0]  fill_q, fill_d;
  logic [ByteW-1:0] crc_q, crc_d;
  logic [ByteW-1:0] sync_q;
  logic             bank_q, bank_d;
  logic             len_ok;
  logic [LenW-1:0]  fill_inc;

  assign len_ok   = (rx_byte_i != '0) &&
                    ({1'b0, rx_byte_i} <= (ByteW+1)'(MaxPayload + 1));
  assign fill_inc = fill_q + LenW'(1);

  always_comb begin
    phase_d = phase_q;
    exp_d   = exp_q;
    cmd_d   = cmd_q;
    fill_d  = fill_q;
    crc_d   = crc_q;
    bank_d  = bank_q;
    push_o  = '0;
    wr_o    = '0;
    push_o.desc.command = cmd_q;
    push_o.desc.len     = exp_q;
    push_o.desc.bank    = bank_q;
    wr_o.addr = {bank_q, fill_q[IdxW-1:0]};
    wr_o.data = rx_byte_i;
    if (in_fire_i) begin
      unique case (phase_q)
        PhHunt: begin
          if (rx_byte_i == sync_q) phase_d = PhLen;
        end
        PhLen: begin
          if (len_ok) begin
            exp_d   = LenW'(rx_byte_i - 8'd1);
            crc_d   = crc_feed(CrcInit, rx_byte_i);
            phase_d = PhCmd;
          end else begin
            phase_d = PhHunt;
          end
        end
        PhCmd: begin
          cmd_d   = rx_byte_i;
          fill_d  = '0;
          crc_d   = crc_feed(crc_q, rx_byte_i);
          phase_d = (exp_q != '0) ? PhPay : PhCrc;
        end
        PhPay: begin
          wr_o.en = 1'b1;
          fill_d  = fill_inc;
          crc_d   = crc_feed(crc_q, rx_byte_i);
          if (fill_inc >= exp_q) phase_d = PhCrc;
        end
        PhCrc: begin
          if (rx_byte_i == crc_q) begin
            push_o.push = 1'b1;
            bank_d      = ~bank_q;
          end
          phase_d = PhHunt;
        end
        default: phase_d = PhHunt;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      exp_q   <= '0;
      cmd_q   <= '0;
      fill_q  <= '0;
      crc_q   <= '0;
      bank_q  <= 1'b0;
      sync_q  <= SyncReset;
    end else begin
      phase_q <= phase_d;
      exp_q   <= exp_d;
      cmd_q   <= cmd_d;
      fill_q  <= fill_d;
      crc_q   <= crc_d;
      bank_q  <= bank_d;
      if (cfg_valid_i) sync_q <= cfg_sync_value_i;
    end
  end

endmodule

>>> design/crc8d_queue.sv
// two-entry descriptor queue, one entry per payload bank
module crc8d_queue import crc8d_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  push_t  push_i,
  input  logic   pop_i,
  output qstat_t stat_o
);

  desc_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign stat_o.valid = (cnt_q != 2'd0);
  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.head  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i.push) mem_q[wr_q] <= push_i.desc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i.push) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      case ({push_i.push, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

>>> design/crc8d_back.sv
// emitter: payload store and per-byte result sequencing
module crc8d_back import crc8d_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  wr_t              wr_i,
  input  qstat_t           stat_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ByteW-1:0] command_o,
  output logic [LenW-1:0]  payload_len_o,
  output logic [IdxW-1:0]  byte_index_o,
  output logic [ByteW-1:0] payload_byte_o,
  output logic             has_data_o,
  output logic             last_o
);

  localparam logic [1:0] BkIdle = 2'd0;
  localparam logic [1:0] BkRead = 2'd1;
  localparam logic [1:0] BkShow = 2'd2;

  logic [ByteW-1:0] store_q [2*MaxPayload];
  logic [ByteW-1:0] rd_q;
  logic [1:0]       state_q, state_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic             rd_en;
  logic             is_last;

  assign has_data_o     = (stat_i.head.len != '0);
  assign is_last        = !has_data_o || ((LenW'(idx_q) + LenW'(1)) == stat_i.head.len);
  assign out_valid_o    = (state_q == BkShow);
  assign command_o      = stat_i.head.command;
  assign payload_len_o  = stat_i.head.len;
  assign byte_index_o   = idx_q;
  assign payload_byte_o = has_data_o ? rd_q : '0;
  assign last_o         = is_last;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    rd_en   = 1'b0;
    pop_o   = 1'b0;
    unique case (state_q)
      BkIdle: begin
        idx_d = '0;
        if (stat_i.valid) state_d = has_data_o ? BkRead : BkShow;
      end
      BkRead: begin
        rd_en   = 1'b1;
        state_d = BkShow;
      end
      BkShow: begin
        if (out_ready_i) begin
          if (is_last) begin
            pop_o   = 1'b1;
            state_d = BkIdle;
          end else begin
            idx_d   = idx_q + IdxW'(1);
            state_d = BkRead;
          end
        end
      end
      default: state_d = BkIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) store_q[wr_i.addr] <= wr_i.data;
    if (rd_en) rd_q <= store_q[{stat_i.head.bank, idx_q}];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkIdle;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

>>> design/crc8_packet_deframer.sv
// top level of the sync / length / crc-8 packet deframer
// takes one received word per cycle while fewer than two validated packets
// wait for output; the parser hunts for the sync word, checks the length
// word (1 to 33), captures the command and payload into one of two payload
// banks and checks the crc-8 (poly 0x07, init 0, msb first) over length,
// command and payload. a good packet is queued as a descriptor; a bad one
// is dropped without a trace. the emitter then sends the run, one result
// word per payload word, each through a bank read state and then a show
// state, with an idle state ahead of each packet, or a single result
// without data for an empty payload. input ready drops only while both
// banks hold packets not yet fully delivered. the sync register may be
// written at any time through its own channel, which is always ready.
module crc8_packet_deframer import crc8d_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration write channel
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [ByteW-1:0] cfg_sync_value_i,
  // received word channel
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] rx_byte_i,
  // result channel
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ByteW-1:0] command_o,
  output logic [LenW-1:0]  payload_len_o,
  output logic [IdxW-1:0]  byte_index_o,
  output logic [ByteW-1:0] payload_byte_o,
  output logic             has_data_o,
  output logic             last_o
);

  push_t  push;
  wr_t    wr;
  qstat_t stat;
  logic   pop;
  logic   in_fire;

  // config write always lands immediately
  assign cfg_ready_o = 1'b1;
  // a free bank exists whenever the queue is not full
  assign in_ready_o  = !stat.full;
  assign in_fire     = in_valid_i && in_ready_o;

  crc8d_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_sync_value_i,
    .in_fire_i (in_fire),
    .rx_byte_i,
    .push_o    (push),
    .wr_o      (wr)
  );

  crc8d_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i (push),
    .pop_i  (pop),
    .stat_o (stat)
  );

  // descriptor stays at the queue head until its last result is taken
  crc8d_back u_back (
    .clk_i,
    .rst_ni,
    .wr_i   (wr),
    .stat_i (stat),
    .pop_o  (pop),
    .out_valid_o,
    .out_ready_i,
    .command_o,
    .payload_len_o,
    .byte_index_o,
    .payload_byte_o,
    .has_data_o,
    .last_o
  );

endmodule

>>> design/crc8d_checker.sv
// port-level checker for the deframer, bound to the top level
module crc8d_port_checker import crc8d_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [ByteW-1:0] command_o,
  input logic [LenW-1:0]  payload_len_o,
  input logic [IdxW-1:0]  byte_index_o,
  input logic [ByteW-1:0] payload_byte_o,
  input logic             has_data_o,
  input logic             last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(command_o) &&
    $stable(payload_len_o) && $stable(byte_index_o) && $stable(payload_byte_o) &&
    $stable(has_data_o) && $stable(last_o))
    else $error("result changed while stalled");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_data_o |-> last_o && payload_len_o == '0 &&
    byte_index_o == '0 && payload_byte_o == '0)
    else $error("empty-payload result malformed");

  a_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_data_o |-> {1'b0, byte_index_o} < payload_len_o)
    else $error("byte index beyond payload length");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_data_o |->
    last_o == (({1'b0, byte_index_o} + LenW'(1)) == payload_len_o))
    else $error("last flag misplaced");

endmodule

bind crc8_packet_deframer crc8d_port_checker u_checker (.*);
